@@ sv/aarm_pkg.sv @@
// Package for the axis-angle rotation matrix core: widths, constants, CORDIC table.
// No dependencies; imported by every module of the block.
package aarm_pkg;

  localparam int COORD_BITS_DEF    = 16;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int FRAC_BITS_DEF     = 14;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int UNIT_FRAC = 15;
  localparam int TRIG_FRAC = 30;
  localparam int MAG_LIMIT_BITS = 17;
  localparam int N2_BITS = 36;
  localparam int NUM_BITS = 64;
  localparam int UNIT_BITS = 17;
  localparam int TRIG_BITS = 33;
  localparam logic signed [TRIG_BITS-1:0] CORDIC_INV_GAIN = 33'sd652032874;

  function automatic logic signed [33:0] atan_turn32(input int k);
    logic signed [33:0] t;
    case (k)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;   2: t = 34'sd167458907;
      3: t = 34'sd85004756;    4: t = 34'sd42667331;    5: t = 34'sd21354465;
      6: t = 34'sd10679838;    7: t = 34'sd5340245;     8: t = 34'sd2670163;
      9: t = 34'sd1335087;     10: t = 34'sd667544;     11: t = 34'sd333772;
      12: t = 34'sd166886;     13: t = 34'sd83443;      14: t = 34'sd41722;
      15: t = 34'sd20861;      16: t = 34'sd10430;      17: t = 34'sd5215;
      18: t = 34'sd2608;       19: t = 34'sd1304;       20: t = 34'sd652;
      21: t = 34'sd326;        22: t = 34'sd163;        23: t = 34'sd81;
      24: t = 34'sd41;         25: t = 34'sd20;         26: t = 34'sd10;
      27: t = 34'sd5;          28: t = 34'sd3;          29: t = 34'sd1;
      30: t = 34'sd1;          default: t = 34'sd0;
    endcase
    return t;
  endfunction

endpackage

@@ sv/aarm_isqrt.sv @@
// Pipelined restoring divider and square root for the unit axis components.
// Depends on aarm_pkg. One quotient bit and one root bit per stage.
module aarm_isqrt import aarm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [N2_BITS-1:0]   num_hi,
  input  logic [N2_BITS-1:0]   den,
  output logic [UNIT_BITS-1:0] root
);
  // Quotient = num_hi * 2^30 / den; num_hi <= den so quotient < 2^31.
  localparam int QB = 31;
  localparam int RB = 16;

  logic [N2_BITS:0]   rem  [QB+1];
  logic [N2_BITS-1:0] dd   [QB+1];
  logic [QB-1:0]      quo  [QB+1];

  always_comb begin
    rem[0] = {1'b0, num_hi};
    dd[0]  = den;
    quo[0] = '0;
  end

  // Divide: one bit per stage, remainder kept below the divisor.
  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [N2_BITS+1:0] tr;
    logic [N2_BITS:0]   rn;
    logic               qb;
    always_comb begin
      tr = (i == 0) ? {1'b0, rem[i]} : {rem[i], 1'b0};
      qb = tr >= {2'b0, dd[i]};
      rn = qb ? (N2_BITS+1)'(tr - {2'b0, dd[i]}) : tr[N2_BITS:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= rn;
        dd[i+1]  <= dd[i];
        quo[i+1] <= {quo[i][QB-2:0], qb};
      end
    end
  end

  // Square root: digit by digit, one root bit per stage.
  logic [QB:0]   sn [RB+1];
  logic [RB:0]   sr [RB+1];
  logic [RB+2:0] sm [RB+1];
  always_comb begin
    sn[0] = {1'b0, quo[QB]};
    sr[0] = '0;
    sm[0] = '0;
  end
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    logic [RB+2:0] trial;
    logic [RB+2:0] rem2;
    logic          ok;
    always_comb begin
      rem2  = {sm[j][RB:0], sn[j][2*(RB-j)-1 -: 2]};
      trial = {sr[j], 2'b01};
      ok    = rem2 >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sn[j+1] <= sn[j];
        sm[j+1] <= ok ? rem2 - trial : rem2;
        sr[j+1] <= {sr[j][RB-1:0], ok};
      end
    end
  end
  assign root = sr[RB];
endmodule

@@ sv/aarm_cordic.sv @@
// Rotation-mode CORDIC pipeline giving cosine and sine in Q.30.
// Depends on aarm_pkg. One micro-rotation per stage, quadrant fold on entry.
module aarm_cordic import aarm_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int DEPTH         = CORDIC_STAGES
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic signed [TRIG_BITS-1:0] cos_q,
  output logic signed [TRIG_BITS-1:0] sin_q
);
  logic [31:0] t;
  logic        flip_in;
  logic signed [33:0] z0;
  always_comb begin
    t = 32'(angle) << (32 - ANGLE_BITS);
    flip_in = (t[31:30] == 2'b01) || (t[31:30] == 2'b10);
    if (flip_in) t = t + 32'h8000_0000;
    z0 = 34'(signed'(t));
  end

  logic signed [TRIG_BITS:0] cx [CORDIC_STAGES+1];
  logic signed [TRIG_BITS:0] cy [CORDIC_STAGES+1];
  logic signed [33:0]        cz [CORDIC_STAGES+1];
  logic                      fl [CORDIC_STAGES+1];
  always_comb begin
    cx[0] = 34'(CORDIC_INV_GAIN);
    cy[0] = '0;
    cz[0] = z0;
    fl[0] = flip_in;
  end

  // Advance one micro-rotation per stage.
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    logic signed [TRIG_BITS:0] dx, dy;
    always_comb begin
      dx = cy[k] >>> k;
      dy = cx[k] >>> k;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        fl[k+1] <= fl[k];
        if (!cz[k][33]) begin
          cx[k+1] <= cx[k] - dx;
          cy[k+1] <= cy[k] + dy;
          cz[k+1] <= cz[k] - atan_turn32(k);
        end else begin
          cx[k+1] <= cx[k] + dx;
          cy[k+1] <= cy[k] - dy;
          cz[k+1] <= cz[k] + atan_turn32(k);
        end
      end
    end
  end

  // Unfold and pad the pipeline to the requested depth.
  logic signed [TRIG_BITS-1:0] dc [DEPTH-CORDIC_STAGES+1];
  logic signed [TRIG_BITS-1:0] ds [DEPTH-CORDIC_STAGES+1];
  always_comb begin
    dc[0] = fl[CORDIC_STAGES] ? TRIG_BITS'(-cx[CORDIC_STAGES]) : TRIG_BITS'(cx[CORDIC_STAGES]);
    ds[0] = fl[CORDIC_STAGES] ? TRIG_BITS'(-cy[CORDIC_STAGES]) : TRIG_BITS'(cy[CORDIC_STAGES]);
  end
  for (genvar p = 0; p < DEPTH - CORDIC_STAGES; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        dc[p+1] <= dc[p];
        ds[p+1] <= ds[p];
      end
    end
  end
  assign cos_q = dc[DEPTH-CORDIC_STAGES];
  assign sin_q = ds[DEPTH-CORDIC_STAGES];
endmodule

@@ sv/aarm_matrix.sv @@
// Rodrigues matrix assembly: products, rounding and saturation, three stages.
// Depends on aarm_pkg.
module aarm_matrix import aarm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [UNIT_BITS:0]   ux,
  input  logic signed [UNIT_BITS:0]   uy,
  input  logic signed [UNIT_BITS:0]   uz,
  input  logic signed [TRIG_BITS-1:0] c,
  input  logic signed [TRIG_BITS-1:0] s,
  output logic [9*(FRAC_BITS+2)-1:0]  entries
);
  localparam int SH = 2 * UNIT_FRAC + TRIG_FRAC - FRAC_BITS;
  localparam int OW = FRAC_BITS + 2;

  // Stage 1: axis outer products and one minus cosine.
  logic signed [35:0] pp [6];
  logic signed [TRIG_BITS+1:0] omc1, c1, s1;
  logic signed [UNIT_BITS:0] ux1, uy1, uz1;
  always_ff @(posedge clk) begin
    if (en) begin
      pp[0] <= ux * ux; pp[1] <= uy * uy; pp[2] <= uz * uz;
      pp[3] <= ux * uy; pp[4] <= ux * uz; pp[5] <= uy * uz;
      omc1 <= (35'sd1 <<< TRIG_FRAC) - 35'(c);
      c1 <= 35'(c); s1 <= 35'(s);
      ux1 <= ux; uy1 <= uy; uz1 <= uz;
    end
  end

  // Stage 2: scale by trig terms.
  logic signed [71:0] q [6];
  logic signed [71:0] sx, sy, sz, cd;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) q[i] <= 72'(pp[i]) * 72'(omc1);
      sx <= (72'(ux1) * 72'(s1)) <<< UNIT_FRAC;
      sy <= (72'(uy1) * 72'(s1)) <<< UNIT_FRAC;
      sz <= (72'(uz1) * 72'(s1)) <<< UNIT_FRAC;
      cd <= 72'(c1) <<< (2 * UNIT_FRAC);
    end
  end

  function automatic logic [OW-1:0] finish(input logic signed [71:0] v);
    logic signed [71:0] r;
    logic signed [71:0] one;
    r = (v + (72'sd1 <<< (SH - 1))) >>> SH;
    one = 72'sd1 <<< FRAC_BITS;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[OW-1:0];
  endfunction

  // Stage 3: sum, round, clamp.
  always_ff @(posedge clk) begin
    if (en) begin
      entries[0*OW +: OW] <= finish(cd + q[0]);
      entries[1*OW +: OW] <= finish(q[3] - sz);
      entries[2*OW +: OW] <= finish(q[4] + sy);
      entries[3*OW +: OW] <= finish(q[3] + sz);
      entries[4*OW +: OW] <= finish(cd + q[1]);
      entries[5*OW +: OW] <= finish(q[5] - sx);
      entries[6*OW +: OW] <= finish(q[4] - sy);
      entries[7*OW +: OW] <= finish(q[5] + sx);
      entries[8*OW +: OW] <= finish(cd + q[2]);
    end
  end
endmodule

@@ sv/axis_angle_rotation_matrix_core.sv @@
// Axis-angle rotation matrix core, fully pipelined.
// Throughput: one request per cycle while the output is not stalled. Most of the
// pipeline depth lies in the divider and square-root stages of axis normalization.
// A stall freezes the whole pipeline; the output register holds the last result.
// Reset (rst, synchronous) clears the valid bits only.
module axis_angle_rotation_matrix_core import aarm_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] axis_x,
  input  logic signed [COORD_BITS-1:0] axis_y,
  input  logic signed [COORD_BITS-1:0] axis_z,
  input  logic [ANGLE_BITS-1:0]        angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [FRAC_BITS+1:0]  row0_col0,
  output logic signed [FRAC_BITS+1:0]  row0_col1,
  output logic signed [FRAC_BITS+1:0]  row0_col2,
  output logic signed [FRAC_BITS+1:0]  row1_col0,
  output logic signed [FRAC_BITS+1:0]  row1_col1,
  output logic signed [FRAC_BITS+1:0]  row1_col2,
  output logic signed [FRAC_BITS+1:0]  row2_col0,
  output logic signed [FRAC_BITS+1:0]  row2_col1,
  output logic signed [FRAC_BITS+1:0]  row2_col2,
  output logic                         axis_was_zero
);
  localparam int OW = FRAC_BITS + 2;
  localparam int NORM_LAT = 2 + 31 + 16;
  localparam int TOTAL = NORM_LAT + 3;
  localparam int CW = (COORD_BITS > 17) ? COORD_BITS : 17;

  logic en;
  logic [TOTAL-1:0] vld;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage A: magnitudes, range reduction to 17 bits, signs.
  logic [CW-1:0] m [3];
  logic [CW-1:0] mx;
  int            shamt;
  logic [16:0]   ma [3];
  logic [2:0]    sg_a, sg_n;
  logic          zero_a;
  always_comb begin
    m[0] = CW'(axis_x[COORD_BITS-1] ? -CW'(axis_x) : CW'(axis_x));
    m[1] = CW'(axis_y[COORD_BITS-1] ? -CW'(axis_y) : CW'(axis_y));
    m[2] = CW'(axis_z[COORD_BITS-1] ? -CW'(axis_z) : CW'(axis_z));
    // Shift until no magnitude exceeds 2^16 (only wide coordinates).
    mx = (m[0] > m[1]) ? m[0] : m[1];
    mx = (mx > m[2]) ? mx : m[2];
    shamt = 0;
    for (int s = CW - 1; s >= 0; s--) begin
      if ((mx >> s) <= CW'(65536)) shamt = s;
    end
    for (int i = 0; i < 3; i++) m[i] = m[i] >> shamt;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) ma[i] <= m[i][16:0];
      sg_a <= {axis_z[COORD_BITS-1], axis_y[COORD_BITS-1], axis_x[COORD_BITS-1]};
      zero_a <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
    end
  end

  // Stage B: squares and their sum.
  logic [N2_BITS-1:0] sq [3];
  logic [N2_BITS-1:0] n2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq[i] <= N2_BITS'(ma[i] * ma[i]);
      n2 <= N2_BITS'(ma[0] * ma[0]) + N2_BITS'(ma[1] * ma[1]) + N2_BITS'(ma[2] * ma[2]);
      sg_n <= sg_a;
    end
  end

  logic [UNIT_BITS-1:0] root [3];
  for (genvar i = 0; i < 3; i++) begin : g_norm
    aarm_isqrt u_sq (.clk(clk), .en(en), .num_hi(sq[i]),
                     .den((n2 == '0) ? N2_BITS'(1) : n2), .root(root[i]));
  end

  // Carry signs and the zero flag alongside the normalizer.
  logic [2:0] sgd [NORM_LAT-2];
  logic       zd  [TOTAL-1];
  always_ff @(posedge clk) begin
    if (en) begin
      sgd[0] <= sg_n;
      for (int i = 1; i < NORM_LAT - 2; i++) sgd[i] <= sgd[i-1];
      zd[0] <= zero_a;
      for (int i = 1; i < TOTAL - 1; i++) zd[i] <= zd[i-1];
    end
  end
  logic signed [UNIT_BITS:0] u [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      u[i] = sgd[NORM_LAT-3][i] ? -$signed({1'b0, root[i]}) : $signed({1'b0, root[i]});
  end

  logic signed [TRIG_BITS-1:0] cq, sin_trig;
  aarm_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES),
                .DEPTH(NORM_LAT)) u_cordic (
    .clk(clk), .en(en), .angle(angle), .cos_q(cq), .sin_q(sin_trig));

  logic [9*OW-1:0] ent;
  aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk(clk), .en(en), .ux(u[0]), .uy(u[1]), .uz(u[2]), .c(cq), .s(sin_trig),
    .entries(ent));

  // Advance valid bits with the data.
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[TOTAL-2:0], in_valid};
  end

  // Output register: identity on a zero axis.
  logic [9*OW-1:0] res;
  logic            zf;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[TOTAL-1];
    if (en) begin
      zf <= zd[TOTAL-2];
      for (int k = 0; k < 9; k++)
        res[k*OW +: OW] <= zd[TOTAL-2] ? ((k % 4 == 0) ? OW'(1) << FRAC_BITS : '0)
                                       : ent[k*OW +: OW];
    end
  end
  assign row0_col0 = res[0*OW +: OW];
  assign row0_col1 = res[1*OW +: OW];
  assign row0_col2 = res[2*OW +: OW];
  assign row1_col0 = res[3*OW +: OW];
  assign row1_col1 = res[4*OW +: OW];
  assign row1_col2 = res[5*OW +: OW];
  assign row2_col0 = res[6*OW +: OW];
  assign row2_col1 = res[7*OW +: OW];
  assign row2_col2 = res[8*OW +: OW];
  assign axis_was_zero = zf;
endmodule

@@ sv/aarm_checker.sv @@
// Port-level checks for the rotation matrix core, bound to the top level.
// Depends on aarm_pkg for the default widths.
module aarm_checker import aarm_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic axis_was_zero,
  input logic [FRAC_BITS_DEF+1:0] row0_col0,
  input logic [FRAC_BITS_DEF+1:0] row0_col1
);
  localparam logic [FRAC_BITS_DEF+1:0] ONE = (FRAC_BITS_DEF+2)'(1) << FRAC_BITS_DEF;

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready not tied to output room");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row0_col0))
    else $error("stalled result changed");
  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && axis_was_zero |-> row0_col0 == ONE && row0_col1 == '0)
    else $error("zero axis not identity");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .axis_was_zero(axis_was_zero),
  .row0_col0(row0_col0), .row0_col1(row0_col1));

@@ dv/tb_axis_angle_rotation_matrix_core.sv @@
// Testbench for the axis-angle rotation matrix core: directed and random requests,
// with a built-in fixed-point predictor of the Rodrigues matrix. Depends on aarm_pkg.
`timescale 1ns / 100ps

module tb_axis_angle_rotation_matrix_core import aarm_pkg::*; ();

  localparam int CB = COORD_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int NST = CORDIC_STAGES_DEF;
  localparam int LATENCY = 53;

  typedef struct {
    logic signed [FB+1:0] m [9];
    logic zero_axis;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CB-1:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic [AB-1:0] angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [FB+1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic axis_was_zero;

  matrix_t expected_q[$];
  int errors = 0;

  always #5 clk = ~clk;

  axis_angle_rotation_matrix_core dut (
    .clk, .rst, .in_valid, .in_ready, .axis_x, .axis_y, .axis_z, .angle,
    .out_valid, .out_ready,
    .row0_col0(r00), .row0_col1(r01), .row0_col2(r02),
    .row1_col0(r10), .row1_col1(r11), .row1_col2(r12),
    .row2_col0(r20), .row2_col1(r21), .row2_col2(r22),
    .axis_was_zero
  );

  // Integer square root, floor.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Round a Q.60 product half up to FB bits and clamp to +-1.
  function automatic logic signed [FB+1:0] round_entry(longint signed q60);
    longint signed v, one;
    one = 64'sd1 << FB;
    v = (q60 + (64'sd1 << (59 - FB))) >>> (60 - FB);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v[FB+1:0];
  endfunction

  function automatic matrix_t rotation_matrix(logic signed [CB-1:0] ax, ay, az,
                                              logic [AB-1:0] ang);
    matrix_t res;
    longint signed comp[3], u[3];
    longint unsigned mag[3], n2;
    logic [31:0] t;
    bit flip;
    longint signed cx, cy, zr, c, s, omc, cd, sx, sy, sz, dx, dy;
    comp[0] = ax; comp[1] = ay; comp[2] = az;
    for (int i = 0; i < 3; i++) mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
    res.zero_axis = 1'b0;
    if (mag[0] == 0 && mag[1] == 0 && mag[2] == 0) begin
      for (int k = 0; k < 9; k++) res.m[k] = (FB+2)'((k % 4 == 0) ? (1 << FB) : 0);
      res.zero_axis = 1'b1;
      return res;
    end
    n2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    for (int i = 0; i < 3; i++) begin
      u[i] = int_sqrt(((mag[i] * mag[i]) << 30) / n2);
      if (comp[i] < 0) u[i] = -u[i];
    end
    // Fold angle into [-1/4, 1/4) turn, rotate, negate back.
    t = 32'(ang) << (32 - AB);
    flip = (t[31:30] == 2'd1) || (t[31:30] == 2'd2);
    if (flip) t = t + 32'h8000_0000;
    zr = longint'(signed'(t));
    cx = CORDIC_INV_GAIN;
    cy = 0;
    for (int k = 0; k < NST && k < 32; k++) begin
      dx = cy >>> k;
      dy = cx >>> k;
      if (zr >= 0) begin
        cx -= dx; cy += dy; zr -= atan_turn32(k);
      end else begin
        cx += dx; cy -= dy; zr += atan_turn32(k);
      end
    end
    c = flip ? -cx : cx;
    s = flip ? -cy : cy;
    omc = (64'sd1 << 30) - c;
    cd = c <<< 30;
    sx = (u[0] * s) <<< 15;
    sy = (u[1] * s) <<< 15;
    sz = (u[2] * s) <<< 15;
    res.m[0] = round_entry(cd + u[0] * u[0] * omc);
    res.m[1] = round_entry(u[0] * u[1] * omc - sz);
    res.m[2] = round_entry(u[0] * u[2] * omc + sy);
    res.m[3] = round_entry(u[1] * u[0] * omc + sz);
    res.m[4] = round_entry(cd + u[1] * u[1] * omc);
    res.m[5] = round_entry(u[1] * u[2] * omc - sx);
    res.m[6] = round_entry(u[2] * u[0] * omc - sy);
    res.m[7] = round_entry(u[2] * u[1] * omc + sx);
    res.m[8] = round_entry(cd + u[2] * u[2] * omc);
    return res;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Send one request; hold valid until accepted.
  task automatic send_request(logic signed [CB-1:0] ax, ay, az, logic [AB-1:0] ang,
                              bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1'b1;
    axis_x <= ax;
    axis_y <= ay;
    axis_z <= az;
    angle <= ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.insert(expected_q.size(), rotation_matrix(ax, ay, az, ang));
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_zero_axis();
    send_request(0, 0, 0, 0, 0);
    send_request(0, 0, 0, 16'h4000, 0);
    send_request(0, 0, 0, 16'hFFFF, 0);
  endtask

  task automatic test_field_extremes();
    send_request(-32768, -32768, -32768, 0, 0);
    send_request(32767, 32767, 32767, 16'hFFFF, 0);
    send_request(-32768, 0, 0, 16'h8000, 0);
    send_request(0, 32767, 0, 16'h4000, 0);
    send_request(0, 0, -1, 16'hC000, 0);
    send_request(1, 0, 0, 16'h2000, 0);
    send_request(-1, 1, -1, 16'h5555, 0);
    send_request(32767, -32768, 1, 16'hAAAA, 0);
  endtask

  // Quarter-turn fold boundaries, a near-zero angle and odd eighth-turn angles.
  task automatic test_angle_folds();
    logic [AB-1:0] angs[10] = '{16'h3FFF, 16'h4001, 16'h7FFF, 16'h8001, 16'hBFFF,
                                16'hC001, 16'h0001, 16'hE000, 16'h6000, 16'hA000};
    foreach (angs[i]) send_request(3, -4, 12, angs[i], 0);
  endtask

  task automatic test_random(int n);
    int kind;
    logic signed [CB-1:0] v[3];
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 9);
      for (int j = 0; j < 3; j++) begin
        if (kind < 6) v[j] = CB'($urandom);
        else if (kind < 8) v[j] = CB'(int'($urandom_range(0, 15)) - 8);
        else v[j] = ($urandom_range(0, 2) == 0) ? '0 :
                    (($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000);
      end
      if ($urandom_range(0, 49) == 0) v = '{default: '0};
      // Long bursts with no gaps now and then.
      send_request(v[0], v[1], v[2], AB'($urandom), (i / 100) % 3 != 1);
      if (i == n / 2) drain_requests();
    end
  endtask

  // Result side: random stalls, check against the oldest expectation.
  always @(posedge clk) begin
    matrix_t e;
    logic signed [FB+1:0] got[9];
    if (!rst && out_valid && out_ready) begin
      got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== e.m[k]) begin
            $error("row%0d_col%0d: expected %0d, got %0d", k / 3, k % 3, e.m[k], got[k]);
            errors++;
          end
        if (axis_was_zero !== e.zero_axis) begin
          $error("axis_was_zero: expected %0b, got %0b", e.zero_axis, axis_was_zero);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if ($time / 20000 % 4 == 3) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_zero_axis();
    test_field_extremes();
    test_angle_folds();
    drain_requests();
    test_random(1130);
    drain_requests();
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

endmodule
